// ===== hdl/mlp_three_layer_inference_defines.svh =====
// Assertion macros for the three-layer perceptron block.
// Depends on nothing; included by the top level.
`ifndef MLP_THREE_LAYER_INFERENCE_DEFINES_SVH
`define MLP_THREE_LAYER_INFERENCE_DEFINES_SVH
`define MLP_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("%s failed", "label");
`define MLP_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("%s failed", "label");
`endif

// ===== hdl/mlp_pkg.sv =====
// Shared types and constants for the perceptron block.
// Depends on nothing.
package mlp_pkg;
  localparam int unsigned CfgWidth = 32;
  localparam int unsigned CfgIdxWidth = 1;
  localparam logic [CfgIdxWidth-1:0] REG_INPUT_SCALE = 1'b0;
  localparam logic [CfgIdxWidth-1:0] REG_INPUT_OFFSET = 1'b1;
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_INFER = 1'b1;
  localparam logic signed [31:0] ScaleReset = 32'sd93239;
  localparam logic signed [31:0] OffsetReset = 32'sd5594;

  typedef struct packed {
    logic [8:0] coef_addr;
    logic signed [23:0] coef_value;
    logic signed [31:0] sample;
    logic req_type;
  } req_t;

  typedef struct packed {
    logic signed [31:0] command_value;
    logic [3:0] output_index;
    logic last;
  } res_t;

  // sequencer phases driving the datapath
  typedef enum logic [2:0] {
    OP_NONE, OP_SCALE, OP_BIAS, OP_MAC, OP_FINISH_H, OP_FINISH_O, OP_RESCALE, OP_OFFSET
  } op_t;

  typedef struct packed {
    op_t op;
    logic [1:0] layer;
    logic [15:0] rd_addr;
    logic rd_valid;
    logic [5:0] unit;
    logic [5:0] src;
    logic load_we;
  } cmd_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) return 32'sh7fffffff;
    else if (v < lo) return 32'sh80000000;
    else return v[31:0];
  endfunction
endpackage

// ===== hdl/mlp_if.sv =====
// Valid/ready channel carrying one payload.
// Depends on nothing; the payload type is a parameter.
interface mlp_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

// ===== hdl/mlp_three_layer_inference.sv =====
// Three-layer perceptron inference, sequenced controller plus shared-MAC datapath.
// A new request is accepted only while the sequencer is idle, so one inference runs
// at a time; each result waits until the previous one has been taken. Load requests
// write the coefficient memory while idle. Reset clears control, the accumulator,
// result valid and hidden stores and sets the scale and offset registers to their
// defaults; the coefficient memory is undefined until written.
module mlp_three_layer_inference #(
  parameter int unsigned HIDDEN = 16,
  parameter int unsigned OUTPUTS = 5,
  parameter int unsigned COEF_DEPTH = 512
) (
  input logic clk,
  input logic rst,
  mlp_if.sink req_ch,
  mlp_if.source res_ch,
  input logic cfg_we,
  input logic [mlp_pkg::CfgIdxWidth-1:0] cfg_index,
  input logic [mlp_pkg::CfgWidth-1:0] cfg_data
);
`include "mlp_three_layer_inference_defines.svh"
  logic signed [31:0] input_scale;
  logic signed [31:0] input_offset;
  mlp_pkg::cmd_t cmd;
  logic take;
  logic res_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_scale <= mlp_pkg::ScaleReset;
      input_offset <= mlp_pkg::OffsetReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mlp_pkg::REG_INPUT_SCALE: input_scale <= cfg_data;
        mlp_pkg::REG_INPUT_OFFSET: input_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  assign take = req_ch.valid && req_ch.ready;

  mlp_ctrl #(.HIDDEN(HIDDEN), .OUTPUTS(OUTPUTS), .COEF_DEPTH(COEF_DEPTH)) u_ctrl (
    .clk, .rst, .req_valid(req_ch.valid), .req_type(req_ch.payload.req_type),
    .req_ready(req_ch.ready), .res_busy(res_busy), .cmd
  );

  mlp_dp #(.HIDDEN(HIDDEN), .OUTPUTS(OUTPUTS), .COEF_DEPTH(COEF_DEPTH)) u_dp (
    .clk, .rst, .cmd, .req(req_ch.payload), .req_take(take),
    .input_scale, .input_offset, .busy(res_busy), .res_valid(res_ch.valid),
    .res_ready(res_ch.ready), .res(res_ch.payload)
  );

  `MLP_ASSERT_NXT(a_hold, clk, rst, res_ch.valid && !res_ch.ready, res_ch.valid)
  `MLP_ASSERT_IMP(a_busy, clk, rst, res_ch.valid, !req_ch.ready)
endmodule

// ===== hdl/mlp_ctrl.sv =====
// Sequencer for the perceptron: steps layers, units and inputs.
// Depends on mlp_pkg.
module mlp_ctrl #(
  parameter int unsigned HIDDEN = 16,
  parameter int unsigned OUTPUTS = 5,
  parameter int unsigned COEF_DEPTH = 512
) (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_type,
  output logic req_ready,
  input logic res_busy,
  output mlp_pkg::cmd_t cmd
);
  localparam int unsigned W1B = 0;
  localparam int unsigned B1B = W1B + HIDDEN;
  localparam int unsigned W2B = B1B + HIDDEN;
  localparam int unsigned B2B = W2B + HIDDEN * HIDDEN;
  localparam int unsigned W3B = B2B + HIDDEN;
  localparam int unsigned B3B = W3B + HIDDEN * OUTPUTS;
  localparam int unsigned YOB = B3B + OUTPUTS;
  localparam int unsigned RSB = YOB + OUTPUTS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCALE = 3'd1;
  localparam logic [2:0] S_BIAS = 3'd2;
  localparam logic [2:0] S_MAC = 3'd3;
  localparam logic [2:0] S_FIN = 3'd4;
  localparam logic [2:0] S_RSC = 3'd5;
  localparam logic [2:0] S_WAIT = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [1:0] layer;
  logic [1:0] layer_next;
  logic [5:0] unit;
  logic [5:0] unit_next;
  logic [5:0] src;
  logic [5:0] src_next;
  logic [1:0] sub;
  logic [1:0] sub_next;
  logic [5:0] nunits;
  logic [5:0] nsrc;
  int unsigned addr;

  assign nunits = (layer == 2'd2) ? 6'(OUTPUTS - 1) : 6'(HIDDEN - 1);
  assign nsrc = 6'(HIDDEN - 1);
  assign req_ready = (state == S_IDLE);

  always_comb begin
    addr = 0;
    unique case (state)
      S_BIAS: begin
        if (layer == 2'd0) addr = B1B + unit;
        else if (layer == 2'd1) addr = B2B + unit;
        else addr = (sub == 2'd0) ? B3B + unit : YOB + unit;
      end
      S_MAC: begin
        if (layer == 2'd0) addr = W1B + unit;
        else if (layer == 2'd1) addr = W2B + src * HIDDEN + unit;
        else addr = W3B + src * OUTPUTS + unit;
      end
      S_RSC: addr = RSB + unit;
      default: addr = 0;
    endcase
  end

  always_comb begin
    state_next = state;
    layer_next = layer;
    unit_next = unit;
    src_next = src;
    sub_next = sub;
    cmd.op = mlp_pkg::OP_NONE;
    cmd.layer = layer;
    cmd.rd_addr = 16'(addr);
    cmd.rd_valid = addr < COEF_DEPTH;
    cmd.unit = unit;
    cmd.src = src;
    cmd.load_we = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (req_type == mlp_pkg::REQ_LOAD) cmd.load_we = 1'b1;
          else state_next = S_SCALE;
        end
        layer_next = 2'd0;
        unit_next = '0;
        src_next = '0;
        sub_next = '0;
      end
      S_SCALE: begin
        cmd.op = mlp_pkg::OP_SCALE;
        state_next = S_BIAS;
      end
      S_BIAS: begin
        if (layer == 2'd2 && sub == 2'd0) begin
          cmd.op = mlp_pkg::OP_BIAS;
          sub_next = 2'd1;
        end else begin
          cmd.op = (layer == 2'd2) ? mlp_pkg::OP_OFFSET : mlp_pkg::OP_BIAS;
          sub_next = '0;
          src_next = '0;
          state_next = S_MAC;
        end
      end
      S_MAC: begin
        cmd.op = mlp_pkg::OP_MAC;
        if (layer == 2'd0 || src == nsrc) state_next = S_FIN;
        else src_next = src + 6'd1;
      end
      S_FIN: begin
        cmd.op = (layer == 2'd2) ? mlp_pkg::OP_FINISH_O : mlp_pkg::OP_FINISH_H;
        if (layer == 2'd2) state_next = S_RSC;
        else if (unit == nunits) begin
          unit_next = '0;
          layer_next = layer + 2'd1;
          state_next = S_BIAS;
        end else begin
          unit_next = unit + 6'd1;
          state_next = S_BIAS;
        end
      end
      S_RSC: begin
        cmd.op = mlp_pkg::OP_RESCALE;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (!res_busy) begin
          if (unit == nunits) state_next = S_IDLE;
          else begin
            unit_next = unit + 6'd1;
            state_next = S_BIAS;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      layer <= '0;
      unit <= '0;
      src <= '0;
      sub <= '0;
    end else begin
      state <= state_next;
      layer <= layer_next;
      unit <= unit_next;
      src <= src_next;
      sub <= sub_next;
    end
  end
endmodule

// ===== hdl/mlp_dp.sv =====
// Datapath: coefficient memory, hidden stores, a shared MAC multiplier, accumulator.
// Depends on mlp_pkg; commanded by mlp_ctrl.
module mlp_dp #(
  parameter int unsigned HIDDEN = 16,
  parameter int unsigned OUTPUTS = 5,
  parameter int unsigned COEF_DEPTH = 512
) (
  input logic clk,
  input logic rst,
  input mlp_pkg::cmd_t cmd,
  input mlp_pkg::req_t req,
  input logic req_take,
  input logic signed [31:0] input_scale,
  input logic signed [31:0] input_offset,
  output logic busy,
  output logic res_valid,
  input logic res_ready,
  output mlp_pkg::res_t res
);
  localparam int unsigned AW = $clog2(COEF_DEPTH);
  localparam int unsigned HW = (HIDDEN > 1) ? $clog2(HIDDEN) : 1;

  logic signed [23:0] mem [COEF_DEPTH];
  logic signed [31:0] h1 [HIDDEN];
  logic signed [31:0] h2 [HIDDEN];
  logic signed [63:0] acc;
  logic signed [31:0] xval;
  logic signed [31:0] sample_q;
  logic signed [31:0] vval;
  logic signed [23:0] rdata;
  logic signed [31:0] hsrc;
  logic signed [63:0] prod;
  logic signed [63:0] hres;
  logic [15:0] load_addr;
  mlp_pkg::op_t op_q;
  logic [1:0] layer_q;
  logic [5:0] unit_q;
  logic [5:0] src_q;

  assign load_addr = 16'(req.coef_addr);

  // registered read: the command is registered alongside so that it meets its data
  always_ff @(posedge clk) begin
    if (cmd.load_we && load_addr < 16'(COEF_DEPTH))
      mem[load_addr[AW-1:0]] <= req.coef_value;
    if (cmd.rd_valid) rdata <= mem[cmd.rd_addr[AW-1:0]];
    else rdata <= '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_q <= mlp_pkg::OP_NONE;
      layer_q <= '0;
      unit_q <= '0;
      src_q <= '0;
    end else begin
      op_q <= cmd.op;
      layer_q <= cmd.layer;
      unit_q <= cmd.unit;
      src_q <= cmd.src;
    end
  end

  assign busy = res_valid || (op_q == mlp_pkg::OP_RESCALE);

  always_comb begin
    if (layer_q == 2'd0) hsrc = xval;
    else if (layer_q == 2'd1) hsrc = h1[src_q[HW-1:0]];
    else hsrc = h2[src_q[HW-1:0]];
  end

  assign prod = 64'(rdata) * 64'(hsrc);
  assign hres = 64'(mlp_pkg::sat32(acc >>> 16));

  always_ff @(posedge clk) begin
    if (req_take && req.req_type == mlp_pkg::REQ_INFER) sample_q <= req.sample;
    if (rst) begin
      acc <= '0;
      res_valid <= 1'b0;
      for (int i = 0; i < HIDDEN; i++) begin
        h1[i] <= '0;
        h2[i] <= '0;
      end
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      unique case (op_q)
        mlp_pkg::OP_SCALE:
          xval <= mlp_pkg::sat32((64'(sample_q) * 64'(input_scale)
                  - (64'(input_offset) <<< 16)) >>> 24);
        mlp_pkg::OP_BIAS: acc <= 64'(rdata) <<< 16;
        mlp_pkg::OP_OFFSET: acc <= acc - (64'(rdata) <<< 16);
        mlp_pkg::OP_MAC: acc <= acc + prod;
        mlp_pkg::OP_FINISH_H: begin
          if (layer_q == 2'd0) h1[unit_q[HW-1:0]] <= hres[63] ? '0 : hres[31:0];
          else h2[unit_q[HW-1:0]] <= hres[63] ? '0 : hres[31:0];
        end
        mlp_pkg::OP_FINISH_O: vval <= hres[31:0];
        mlp_pkg::OP_RESCALE: begin
          res.command_value <= mlp_pkg::sat32((64'(vval) * 64'(rdata)) >>> 16);
          res.output_index <= unit_q[3:0];
          res.last <= (unit_q == 6'(OUTPUTS - 1));
          res_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule
